FILE: hdl/pusz_pkg.sv
// Shared types and constants for the 11-bit sum-zero polynomial unpacker.
package pusz_pkg;

    localparam int BYTE_W  = 8;
    localparam int COEFF_W = 11;
    localparam int POS_W   = 10;
    localparam int BUF_W   = 18;
    localparam int HELD_W  = 5;

    localparam int DEF_HALF_LEN   = 347;
    localparam int DEF_RING_ORDER = 694;

    // Result queue depth; the unpacker fires only when two slots are free.
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [COEFF_W-1:0] value;
        logic [POS_W-1:0]   position;
        logic               last;
    } coeff_word_t;

    typedef struct packed {
        logic first;
        logic second;
    } push_t;

endpackage

FILE: hdl/pusz_unpack.sv
// Bit gathering, half sums and sum-zero reconstruction for one byte.
module pusz_unpack #(
    parameter int HALF_LEN   = pusz_pkg::DEF_HALF_LEN,
    parameter int RING_ORDER = pusz_pkg::DEF_RING_ORDER
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          fire,
    input  logic [pusz_pkg::BYTE_W-1:0]   byte_in,
    output pusz_pkg::coeff_word_t         res0,
    output pusz_pkg::coeff_word_t         res1,
    output pusz_pkg::push_t               push
);
    import pusz_pkg::*;

    localparam logic [POS_W-1:0] FIRST_LAST = POS_W'(HALF_LEN - 2);
    localparam logic [POS_W-1:0] MID_POS    = POS_W'(HALF_LEN - 1);
    localparam logic [POS_W-1:0] FINAL_IDX  = POS_W'(2 * HALF_LEN - 3);
    localparam logic [POS_W-1:0] FINAL_POS  = POS_W'(RING_ORDER - 1);

    logic [BUF_W-1:0]   buf_reg, buf_next;
    logic [HELD_W-1:0]  held_reg, held_next;
    logic [POS_W-1:0]   count_reg, count_next;
    logic [COEFF_W-1:0] fsum_reg, fsum_next;
    logic [COEFF_W-1:0] ssum_reg, ssum_next;

    logic [BUF_W-1:0]   merged;
    logic [HELD_W-1:0]  held_sum;
    logic               done;
    logic [COEFF_W-1:0] coef;
    logic               in_first;
    logic [COEFF_W-1:0] fsum_add, ssum_add;
    logic               mid, fin;

    // At most ten bits are ever held, so the byte always fits the buffer.
    assign merged   = buf_reg | ({{(BUF_W-BYTE_W){1'b0}}, byte_in} << held_reg[3:0]);
    assign held_sum = held_reg + HELD_W'(BYTE_W);
    assign done     = held_sum >= HELD_W'(COEFF_W);
    assign coef     = merged[COEFF_W-1:0];
    assign in_first = count_reg < MID_POS;
    assign fsum_add = fsum_reg + coef;
    assign ssum_add = ssum_reg + coef;
    assign mid      = done && (count_reg == FIRST_LAST);
    assign fin      = done && !mid && (count_reg >= FINAL_IDX);

    always_comb
    begin
        res0.value    = coef;
        res0.position = in_first ? count_reg : count_reg + POS_W'(1);
        res0.last     = 1'b0;
        res1.value    = mid ? (COEFF_W'(0) - fsum_add) : (COEFF_W'(0) - ssum_add);
        res1.position = mid ? MID_POS : FINAL_POS;
        res1.last     = !mid;
        push.first    = fire && done;
        push.second   = fire && (mid || fin);
    end

    always_comb
    begin
        buf_next   = buf_reg;
        held_next  = held_reg;
        count_next = count_reg;
        fsum_next  = fsum_reg;
        ssum_next  = ssum_reg;
        if (fire)
        begin
            if (!done)
            begin
                buf_next  = merged;
                held_next = held_sum;
            end
            else if (fin)
            begin
                // Padding bits of the final byte are dropped with the state.
                buf_next   = '0;
                held_next  = '0;
                count_next = '0;
                fsum_next  = '0;
                ssum_next  = '0;
            end
            else
            begin
                buf_next   = merged >> COEFF_W;
                held_next  = held_sum - HELD_W'(COEFF_W);
                count_next = count_reg + POS_W'(1);
                if (in_first)
                begin
                    fsum_next = fsum_add;
                end
                else
                begin
                    ssum_next = ssum_add;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg   <= '0;
            held_reg  <= '0;
            count_reg <= '0;
            fsum_reg  <= '0;
            ssum_reg  <= '0;
        end
        else
        begin
            buf_reg   <= buf_next;
            held_reg  <= held_next;
            count_reg <= count_next;
            fsum_reg  <= fsum_next;
            ssum_reg  <= ssum_next;
        end
    end

endmodule

FILE: hdl/pusz_queue.sv
// Small result queue that takes up to two words a cycle and gives one.
module pusz_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  pusz_pkg::push_t       push,
    input  pusz_pkg::coeff_word_t wr0,
    input  pusz_pkg::coeff_word_t wr1,
    output logic                  room_two,
    output logic                  rd_valid,
    input  logic                  rd_ready,
    output pusz_pkg::coeff_word_t rd_word
);
    import pusz_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    coeff_word_t      mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             pop;
    logic [CNT_W-1:0] n_push;

    assign pop      = rd_valid && rd_ready;
    assign n_push   = CNT_W'(push.first) + CNT_W'(push.second);
    assign rd_valid = cnt_reg != '0;
    assign rd_word  = mem_reg[rd_ptr_reg];
    assign room_two = cnt_reg <= CNT_W'(QUEUE_DEPTH - 2);

    assign wr_ptr_next = wr_ptr_reg + PTR_W'(n_push);
    assign rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
    assign cnt_next    = cnt_reg + n_push - CNT_W'(pop);

    always_ff @(posedge clk)
    begin
        if (push.first)
        begin
            mem_reg[wr_ptr_reg] <= wr0;
        end
        if (push.second)
        begin
            mem_reg[wr_ptr_reg + PTR_W'(1)] <= wr1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

FILE: hdl/poly_11bit_unpack_sum_zero.sv
// Top level of the 11-bit sum-zero polynomial unpacker.
//
//   channel   signals                                  word
//   -------   --------------------------------------   -------------------------
//   byte in   byte_valid, byte_ready, packed_byte      one packed byte, LSB first
//   coeff out coeff_valid, coeff_ready, coeff_value,   one coefficient and its
//             coeff_position, last_of_poly             position in the polynomial
//
// A byte is registered on acceptance and unpacked once the result queue has two
// free slots; a byte that completes a coefficient writes it to the queue as it is
// unpacked, and the word can be taken from there; one byte is taken every cycle
// while the four-entry result queue has two free slots.
// Reset clears the gathered bits, counters and half sums; no clearing pass.
// A stalled output fills the queue and then holds the byte input not ready.
module poly_11bit_unpack_sum_zero #(
    parameter int HALF_LEN   = pusz_pkg::DEF_HALF_LEN,
    parameter int RING_ORDER = pusz_pkg::DEF_RING_ORDER
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          byte_valid,
    output logic                          byte_ready,
    input  logic [pusz_pkg::BYTE_W-1:0]   packed_byte,
    output logic                          coeff_valid,
    input  logic                          coeff_ready,
    output logic [pusz_pkg::COEFF_W-1:0]  coeff_value,
    output logic [pusz_pkg::POS_W-1:0]    coeff_position,
    output logic                          last_of_poly
);
    import pusz_pkg::*;

    logic [BYTE_W-1:0] byte_reg;
    logic              stage_valid_reg, stage_valid_next;
    logic              fire;
    logic              room_two;
    coeff_word_t       res0, res1, head;
    push_t             push;

    assign fire             = stage_valid_reg && room_two;
    assign byte_ready       = !stage_valid_reg || fire;
    assign stage_valid_next = byte_ready ? byte_valid : stage_valid_reg;

    always_ff @(posedge clk)
    begin
        if (byte_valid && byte_ready)
        begin
            byte_reg <= packed_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    pusz_unpack #(
        .HALF_LEN   (HALF_LEN),
        .RING_ORDER (RING_ORDER)
    ) u_unpack (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .byte_in (byte_reg),
        .res0    (res0),
        .res1    (res1),
        .push    (push)
    );

    pusz_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr0      (res0),
        .wr1      (res1),
        .room_two (room_two),
        .rd_valid (coeff_valid),
        .rd_ready (coeff_ready),
        .rd_word  (head)
    );

    assign coeff_value    = head.value;
    assign coeff_position = head.position;
    assign last_of_poly   = head.last;

endmodule

FILE: hdl/pusz_checker.sv
// Port-level checks for the unpacker, bound to the top level.
module pusz_checker #(
    parameter int HALF_LEN   = pusz_pkg::DEF_HALF_LEN,
    parameter int RING_ORDER = pusz_pkg::DEF_RING_ORDER
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          coeff_valid,
    input logic                          coeff_ready,
    input logic [pusz_pkg::COEFF_W-1:0]  coeff_value,
    input logic [pusz_pkg::POS_W-1:0]    coeff_position,
    input logic                          last_of_poly
);
    import pusz_pkg::*;

    localparam logic [POS_W-1:0] FINAL_POS = POS_W'(RING_ORDER - 1);
    localparam logic [POS_W-1:0] MAX_PACK  = POS_W'(2 * HALF_LEN - 2);

    a_valid_holds : assert property (@(posedge clk) disable iff (!rst_n)
        coeff_valid && !coeff_ready |=> coeff_valid)
        else $error("coefficient word dropped while stalled");

    a_word_stable : assert property (@(posedge clk) disable iff (!rst_n)
        coeff_valid && !coeff_ready |=>
            $stable(coeff_value) && $stable(coeff_position) && $stable(last_of_poly))
        else $error("coefficient word changed while stalled");

    a_last_pos : assert property (@(posedge clk) disable iff (!rst_n)
        coeff_valid && last_of_poly |-> coeff_position == FINAL_POS)
        else $error("last word is not at the final position");

    a_pos_range : assert property (@(posedge clk) disable iff (!rst_n)
        coeff_valid |-> coeff_position <= MAX_PACK || coeff_position == FINAL_POS)
        else $error("coefficient position out of range");

endmodule

bind poly_11bit_unpack_sum_zero pusz_checker #(
    .HALF_LEN   (HALF_LEN),
    .RING_ORDER (RING_ORDER)
) u_pusz_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .coeff_valid    (coeff_valid),
    .coeff_ready    (coeff_ready),
    .coeff_value    (coeff_value),
    .coeff_position (coeff_position),
    .last_of_poly   (last_of_poly)
);
